// File: src/epg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_pkg
// Shared constants, types and the sine table generator for the equal-power
// pan gain block.
// ----------------------------------------------------------------------------
package epg_pkg;

    // Field widths
    localparam int PAN_W   = 16;
    localparam int PHASE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int ENTRY_W = 31;   // table entry, unsigned Q30, up to 2^30

    // Fixed-point constants
    localparam logic signed [16:0] PAN_ONE     = 17'sd16384;
    localparam logic [PHASE_W-1:0] PHASE_FULL  = 16'd32768;   // phase of pi/2
    localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 16'd32768;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]        ONE_Q30     = 64'd1073741824;

    // Stage enables from the top-level pipeline control to each lane
    typedef struct packed {
        logic en_s2;   // table read stage
        logic en_s3;   // interpolation stage
        logic en_s4;   // rounding / output stage
    } t_pipe_ctl;

    // Entry k of a quarter-wave sine table with 2^addr_bits steps, Q30.
    // Taylor series up to x^15, evaluated at elaboration only.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [64:0] sum;
        x    = ((64'(k) * HALF_PI_Q30) + (64'd1 << (addr_bits - 1))) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({1'b0, x});
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed({1'b0, term});
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({1'b0, ONE_Q30})) begin
            sum = $signed({1'b0, ONE_Q30});
        end
        return sum[ENTRY_W-1:0];
    endfunction

endpackage

// File: src/epg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_in_if
// Valid/ready channel carrying one pan position.
// ----------------------------------------------------------------------------
interface epg_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [epg_pkg::PAN_W-1:0]   pan_position;

    modport source (output valid, output pan_position, input ready);
    modport sink   (input valid, input pan_position, output ready);
endinterface

// File: src/epg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_out_if
// Valid/ready channel carrying one pair of left/right gains.
// ----------------------------------------------------------------------------
interface epg_out_if;
    logic                          valid;
    logic                          ready;
    logic [epg_pkg::GAIN_W-1:0]    left_gain;
    logic [epg_pkg::GAIN_W-1:0]    right_gain;

    modport source (output valid, output left_gain, output right_gain, input ready);
    modport sink   (input valid, input left_gain, input right_gain, output ready);
endinterface

// File: src/equal_power_pan_gains.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_power_pan_gains
// Equal-power (sine/cosine) pan law: one pan position in, left and right
// gains out, from an interpolated quarter-wave sine table.
//
//   channel   direction  payload                          handshake
//   i_pan     in         pan_position  s16 Q2.14          valid/ready
//   o_gain    out        left_gain, right_gain  u16 Q15   valid/ready
//
// One transfer per cycle in and out while o_gain.ready stays high; the four
// register stages are: clamp to phase, table read, interpolation multiply-add,
// round to Q15 (the output register).
// Reset clears only the stage valid bits; payload registers are not reset.
// Back-pressure stops only the stages that hold data; empty stages keep filling.
// ----------------------------------------------------------------------------
module equal_power_pan_gains #(
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    epg_in_if.sink        i_pan,
    epg_out_if.source     o_gain
);

    localparam int PW = epg_pkg::PHASE_W;

    logic [3:0]              r_vld;
    logic [3:0]              w_rdy;
    epg_pkg::t_pipe_ctl      w_ctl;
    logic signed [16:0]      n_pan;
    logic signed [16:0]      n_clamp;
    logic signed [16:0]      n_sum;
    logic [PW-1:0]           n_phase_r;
    logic [PW-1:0]           n_phase_l;
    logic [PW-1:0]           r_phase_r;
    logic [PW-1:0]           r_phase_l;

    // Stage advance: a stage loads when it is empty or the next one moves
    always_comb begin
        w_rdy[3] = o_gain.ready || !r_vld[3];
        w_rdy[2] = w_rdy[3] || !r_vld[2];
        w_rdy[1] = w_rdy[2] || !r_vld[1];
        w_rdy[0] = w_rdy[1] || !r_vld[0];
        w_ctl.en_s2 = w_rdy[1];
        w_ctl.en_s3 = w_rdy[2];
        w_ctl.en_s4 = w_rdy[3];
    end

    assign i_pan.ready  = w_rdy[0];
    assign o_gain.valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_pan.valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Stage 1: clamp to -1..+1 and shift to phase 0..pi/2; left uses the complement
    always_comb begin
        n_pan = 17'(i_pan.pan_position);
        priority if (n_pan > epg_pkg::PAN_ONE) begin
            n_clamp = epg_pkg::PAN_ONE;
        end else if (n_pan < -epg_pkg::PAN_ONE) begin
            n_clamp = -epg_pkg::PAN_ONE;
        end else begin
            n_clamp = n_pan;
        end
        n_sum     = n_clamp + epg_pkg::PAN_ONE;
        n_phase_r = n_sum[PW-1:0];
        n_phase_l = epg_pkg::PHASE_FULL - n_phase_r;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_phase_r <= n_phase_r;
            r_phase_l <= n_phase_l;
        end
    end

    // Left gain = sin(pi/2 - angle), right gain = sin(angle)
    epg_sine_lane #(.ADDR_BITS(TABLE_ADDR_BITS)) u_lane_left (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_phase (r_phase_l),
        .o_gain  (o_gain.left_gain)
    );

    epg_sine_lane #(.ADDR_BITS(TABLE_ADDR_BITS)) u_lane_right (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_phase (r_phase_r),
        .o_gain  (o_gain.right_gain)
    );

`ifndef NO_ASSERTIONS
    // An accepted transfer always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pan.valid && i_pan.ready |=> r_vld[0])
        else $error("accepted pan position not captured in stage 1");

    // The two lane phases always add up to a quarter turn
    a_phase_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ({1'b0, r_phase_r} + {1'b0, r_phase_l}) == {1'b0, epg_pkg::PHASE_FULL})
        else $error("left/right phases do not complement");

    // Gains never exceed unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gain.valid |-> (o_gain.left_gain <= epg_pkg::GAIN_UNITY) &&
                         (o_gain.right_gain <= epg_pkg::GAIN_UNITY))
        else $error("gain above unity");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_gain.valid)
        else $error("output valid after reset");
`endif

endmodule

// File: src/epg_sine_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_sine_lane
// Interpolated quarter-wave sine of a 0..pi/2 phase, three register stages:
// table read, interpolation multiply-add, round to Q15.
// ----------------------------------------------------------------------------
module epg_sine_lane #(
    parameter int ADDR_BITS = 8
) (
    input  logic                             i_clk,
    input  epg_pkg::t_pipe_ctl               i_ctl,
    input  logic [epg_pkg::PHASE_W-1:0]      i_phase,
    output logic [epg_pkg::GAIN_W-1:0]       o_gain
);

    localparam int N_STEPS = 1 << ADDR_BITS;
    localparam int FRAC_W  = epg_pkg::PHASE_W - 1 - ADDR_BITS;
    localparam int IDX_W   = ADDR_BITS + 1;
    localparam int EW      = epg_pkg::ENTRY_W;

    // Constant sine table, N_STEPS + 1 entries
    logic [EW-1:0] w_rom [0:N_STEPS];

    for (genvar k = 0; k <= N_STEPS; k++) begin : g_rom
        localparam logic [EW-1:0] ENTRY = epg_pkg::sine_entry(k, ADDR_BITS);
        assign w_rom[k] = ENTRY;
    end

    logic [IDX_W-1:0]  n_idx_a;
    logic [IDX_W-1:0]  n_idx_b;
    logic [EW-1:0]     n_a;
    logic [EW-1:0]     n_d;
    logic [EW-1:0]     r_a;
    logic [EW-1:0]     r_d;
    logic [FRAC_W-1:0] r_frac;
    logic [EW+FRAC_W-1:0] n_prod;
    logic [EW-1:0]     n_v;
    logic [EW-1:0]     r_v;
    logic [EW:0]       n_round;
    logic [EW-15:0]    n_q;
    logic [epg_pkg::GAIN_W-1:0] n_gain;
    logic [epg_pkg::GAIN_W-1:0] r_gain;

    // Stage 2: split phase, read both neighbors; last entry has no upper neighbor
    always_comb begin
        n_idx_a = i_phase[epg_pkg::PHASE_W-1:FRAC_W];
        n_idx_b = (n_idx_a == IDX_W'(N_STEPS)) ? n_idx_a : n_idx_a + 1'b1;
        n_a     = w_rom[n_idx_a];
        n_d     = w_rom[n_idx_b] - n_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_a    <= n_a;
            r_d    <= n_d;
            r_frac <= i_phase[FRAC_W-1:0];
        end
    end

    // Stage 3: a + floor(d * frac / 2^FRAC_W)
    always_comb begin
        n_prod = {{FRAC_W{1'b0}}, r_d} * {{EW{1'b0}}, r_frac};
        n_v    = r_a + n_prod[EW+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s3) begin
            r_v <= n_v;
        end
    end

    // Stage 4: round half up to Q15, saturate at unity
    always_comb begin
        n_round = {1'b0, r_v} + (EW+1)'(1 << 14);
        n_q     = n_round[EW:15];
        n_gain  = (n_q > (EW-14)'(epg_pkg::GAIN_UNITY)) ? epg_pkg::GAIN_UNITY
                                                         : n_q[epg_pkg::GAIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s4) begin
            r_gain <= n_gain;
        end
    end

    assign o_gain = r_gain;

endmodule

// File: tb/equal_power_pan_gains_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_power_pan_gains_tb
// Self-checking bench for the equal-power pan gain block. Pan positions are
// sent over the input channel with random gaps, and the gain pairs are taken
// with random stalls. Each output transfer is checked against a gain pair
// computed in the bench from its own quarter-wave sine table.
// ----------------------------------------------------------------------------
module equal_power_pan_gains_tb;

    localparam int TAB_BITS   = 8;
    localparam int TAB_N      = 1 << TAB_BITS;
    localparam int FRAC_W     = 15 - TAB_BITS;
    localparam int PAN_FULL   = 16384;
    localparam int RAND_ITEMS = 1050;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYC   = 16;

    // One pending input transfer, or a marker that holds the sender until drained
    typedef struct {
        bit                                  drain;
        bit                                  burst;
        logic signed [epg_pkg::PAN_W-1:0]    pan;
    } t_pan_item;

    typedef struct {
        logic signed [epg_pkg::PAN_W-1:0]    pan;
        logic [epg_pkg::GAIN_W-1:0]          left;
        logic [epg_pkg::GAIN_W-1:0]          right;
    } t_gain_pair;

    logic i_clk = 1'b0;
    logic i_rst_n;

    epg_in_if  pan_ch ();
    epg_out_if gain_ch ();

    equal_power_pan_gains #(
        .TABLE_ADDR_BITS(TAB_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pan   (pan_ch),
        .o_gain  (gain_ch)
    );

    t_pan_item          pan_queue[$];
    t_gain_pair         gain_expect[$];
    longint unsigned    sine_tab [0:TAB_N];

    logic   pan_took;
    logic   gain_took;
    int     send_gap;
    int     recv_stall;
    int     gains_seen;
    int     idle_cycles;
    int     err_count;

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Known values on every input from time zero
    initial begin
        i_rst_n              = 1'b0;
        pan_ch.valid         = 1'b0;
        pan_ch.pan_position  = '0;
        gain_ch.ready        = 1'b0;
        pan_took             = 1'b0;
        gain_took            = 1'b0;
        send_gap             = 0;
        recv_stall           = 0;
        gains_seen           = 0;
        idle_cycles          = 0;
        err_count            = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sin of a Q30 angle in 0..pi/2, Taylor series through x^15, Q30 out
    function automatic longint unsigned taylor_sine(input longint unsigned ang);
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(epg_pkg::ONE_Q30)) begin
            acc = longint'(epg_pkg::ONE_Q30);
        end
        return longint'(acc);
    endfunction

    // Table of sine at k/TAB_N * pi/2
    initial begin
        longint unsigned ang;
        for (int k = 0; k <= TAB_N; k++) begin
            ang = (longint'(k) * epg_pkg::HALF_PI_Q30 + (TAB_N >> 1)) / TAB_N;
            sine_tab[k] = taylor_sine(ang);
        end
    end

    // Interpolated quarter sine, phase 0..32768 = 0..pi/2, Q15 out
    function automatic logic [epg_pkg::GAIN_W-1:0] quarter_sine(input int unsigned ph);
        int unsigned      idx;
        int unsigned      fr;
        longint unsigned  v;
        if (ph > 32768) begin
            ph = 32768;
        end
        idx = ph >> FRAC_W;
        fr  = ph & ((1 << FRAC_W) - 1);
        v   = sine_tab[idx];
        if (idx < TAB_N && fr != 0) begin
            v = v + (((sine_tab[idx + 1] - sine_tab[idx]) * fr) >> FRAC_W);
        end
        v = (v + (1 << 14)) >> 15;
        if (v > 32768) begin
            v = 32768;
        end
        return v[epg_pkg::GAIN_W-1:0];
    endfunction

    // Clamp to full left / full right, then cos and sin of the pan angle
    function automatic t_gain_pair predict_gains(
        input logic signed [epg_pkg::PAN_W-1:0] pan);
        t_gain_pair   g;
        int           p;
        int unsigned  phase;
        p = pan;
        if (p > PAN_FULL) begin
            p = PAN_FULL;
        end
        if (p < -PAN_FULL) begin
            p = -PAN_FULL;
        end
        phase   = p + PAN_FULL;
        g.pan   = pan;
        g.left  = quarter_sine(32768 - phase);
        g.right = quarter_sine(phase);
        return g;
    endfunction

    function automatic int draw_wait(input bit burst);
        if (burst || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic void add_pan(input logic signed [epg_pkg::PAN_W-1:0] pan,
                                    input bit burst);
        t_pan_item it;
        it.drain = 1'b0;
        it.burst = burst;
        it.pan   = pan;
        pan_queue.push_back(it);
    endfunction

    function automatic void add_drain();
        t_pan_item it;
        it.drain = 1'b1;
        it.burst = 1'b0;
        it.pan   = '0;
        pan_queue.push_back(it);
    endfunction

    // Input driver: next item after its gap, drain markers hold until empty
    always @(negedge i_clk) begin
        t_pan_item nxt;
        if (!i_rst_n) begin
            pan_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!pan_ch.valid || pan_took) begin
            if (send_gap > 0) begin
                pan_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pan_queue.size() == 0) begin
                pan_ch.valid <= 1'b0;
            end else if (pan_queue[0].drain) begin
                pan_ch.valid <= 1'b0;
                if (gain_expect.size() == 0) begin
                    void'(pan_queue.pop_front());
                end
            end else begin
                nxt = pan_queue.pop_front();
                pan_ch.valid        <= 1'b1;
                pan_ch.pan_position <= nxt.pan;
                send_gap            <= draw_wait(nxt.burst);
            end
        end
    end

    // Output ready: random stall per result, free-running stretches
    always @(negedge i_clk) begin
        int s;
        if (!i_rst_n) begin
            gain_ch.ready <= 1'b0;
            recv_stall    <= 0;
        end else if (gain_took) begin
            s = draw_wait((gains_seen % 256) >= 192);
            gain_ch.ready <= (s == 0);
            recv_stall    <= (s == 0) ? 0 : s - 1;
        end else if (recv_stall > 0) begin
            gain_ch.ready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end else begin
            gain_ch.ready <= 1'b1;
        end
    end

    // Monitor: check output transfers, then record input transfers
    always @(posedge i_clk) begin
        t_gain_pair exp_g;
        if (!i_rst_n) begin
            pan_took  <= 1'b0;
            gain_took <= 1'b0;
        end else begin
            if (gain_ch.valid && gain_ch.ready) begin
                gains_seen <= gains_seen + 1;
                if (gain_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected gain transfer L=%0d R=%0d",
                                              gain_ch.left_gain, gain_ch.right_gain));
                end else begin
                    exp_g = gain_expect.pop_front();
                    if (gain_ch.left_gain !== exp_g.left) begin
                        report_mismatch($sformatf("pan %0d left_gain %0d, expected %0d",
                                                  exp_g.pan, gain_ch.left_gain, exp_g.left));
                    end
                    if (gain_ch.right_gain !== exp_g.right) begin
                        report_mismatch($sformatf("pan %0d right_gain %0d, expected %0d",
                                                  exp_g.pan, gain_ch.right_gain, exp_g.right));
                    end
                end
            end
            if (pan_ch.valid && pan_ch.ready) begin
                gain_expect.push_back(predict_gains(pan_ch.pan_position));
            end
            pan_took  <= pan_ch.valid && pan_ch.ready;
            gain_took <= gain_ch.valid && gain_ch.ready;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((pan_ch.valid && pan_ch.ready) || (gain_ch.valid && gain_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("equal_power_pan_gains_tb NOT OK");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin
        int r;
        // clamps, extremes, table ends and segment edges
        add_pan(-16'sd32768, 1'b0);
        add_pan(16'sd32767, 1'b0);
        add_pan(-16'sd16385, 1'b0);
        add_pan(-16'sd16384, 1'b0);
        add_pan(-16'sd16383, 1'b0);
        add_pan(16'sd16383, 1'b0);
        add_pan(16'sd16384, 1'b0);
        add_pan(16'sd16385, 1'b0);
        add_pan(16'sd0, 1'b0);
        add_pan(-16'sd1, 1'b0);
        add_pan(16'sd1, 1'b0);
        add_pan(-16'sd16256, 1'b0);
        add_pan(-16'sd16257, 1'b0);
        add_pan(16'sd16256, 1'b0);
        add_pan(16'sd16255, 1'b0);
        add_pan(-16'sd8192, 1'b0);
        add_pan(16'sd8192, 1'b0);
        add_pan(16'sh5555, 1'b0);
        add_pan(16'shAAAA, 1'b0);
        add_pan(-16'sd256, 1'b0);
        add_pan(16'sd127, 1'b0);
        add_drain();

        // mostly inside the pan range, some anywhere in 16 bits
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                r = $urandom_range(0, 65535);
            end else begin
                r = $urandom_range(0, 2 * PAN_FULL) - PAN_FULL;
            end
            add_pan(r[epg_pkg::PAN_W-1:0], (i % 256) >= 160 && (i % 256) < 224);
            if (i == RAND_ITEMS / 2) begin
                add_drain();
            end
        end

        while (pan_queue.size() != 0 || pan_ch.valid || gain_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYC) @(posedge i_clk);

        if (err_count == 0) begin
            $display("equal_power_pan_gains_tb OK");
        end else begin
            $display("equal_power_pan_gains_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/epg_pkg.sv
src/epg_in_if.sv
src/epg_out_if.sv
src/epg_sine_lane.sv
src/equal_power_pan_gains.sv
tb/equal_power_pan_gains_tb.sv
